/* rtl/core/mvd_pkg.sv */
// Shared types, constants and register indexes of the magnetic vehicle detector.
package mvd_pkg;

  localparam int HISTORY_DEPTH = 19;
  localparam int BASELINE_TAPS = 8;
  localparam int SUM_TAPS      = (BASELINE_TAPS < HISTORY_DEPTH) ? BASELINE_TAPS : HISTORY_DEPTH;

  localparam int Z_W     = 11;
  localparam int SUM_W   = Z_W + $clog2(SUM_TAPS + 1);
  localparam int WARM_W  = 7;
  localparam int RUN_W   = 5;
  localparam int CNT_W   = 4;
  localparam int TOTAL_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [WARM_W-1:0] WARMUP_CAP = 7'd100;

  localparam logic [Z_W-1:0]    QUIET_THRESHOLD_RST  = 11'd30;
  localparam logic [Z_W-1:0]    DETECT_THRESHOLD_RST = 11'd70;
  localparam logic [CNT_W-1:0]  ENTER_COUNT_RST      = 4'd4;
  localparam logic [CNT_W-1:0]  LEAVE_COUNT_RST      = 4'd8;
  localparam logic [WARM_W-1:0] FILL_SAMPLES_RST     = 7'd53;
  localparam logic [WARM_W-1:0] ARM_SAMPLES_RST      = 7'd55;

  localparam logic [RUN_W-1:0] ENTER_HOLD_OFFSET = 5'd2;
  localparam logic [RUN_W-1:0] LEAVE_HOLD_OFFSET = 5'd3;

  localparam logic [CFG_IDX_W-1:0] REG_QUIET_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTER_COUNT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAVE_COUNT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_SAMPLES     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_SAMPLES      = 3'd5;

  typedef logic [HISTORY_DEPTH-1:0][Z_W-1:0] history_t;

  typedef struct packed {
    logic [Z_W-1:0]    quiet_threshold;
    logic [Z_W-1:0]    detect_threshold;
    logic [CNT_W-1:0]  enter_count;
    logic [CNT_W-1:0]  leave_count;
    logic [WARM_W-1:0] fill_samples;
    logic [WARM_W-1:0] arm_samples;
  } cfg_t;

  typedef struct packed {
    logic [WARM_W-1:0]  warmup_count;
    history_t           z_history;
    logic [RUN_W-1:0]   high_run;
    logic [RUN_W-1:0]   low_run;
    logic               present_flag;
    logic [TOTAL_W-1:0] vehicle_total;
  } state_t;

endpackage

/* rtl/core/mvd_step.sv */
// Per-sample next-state logic: history update, baseline, deviation and run counters.
module mvd_step (
  input  logic [7:0]           z_high_byte,
  input  logic [7:0]           z_low_byte,
  input  mvd_pkg::cfg_t        cfg,
  input  mvd_pkg::state_t      cur,
  output mvd_pkg::state_t      nxt,
  output logic [mvd_pkg::Z_W-1:0] baseline
);

  logic [mvd_pkg::Z_W-1:0]    z;
  logic                       warm_inc;
  logic [mvd_pkg::WARM_W-1:0] warm_new;
  logic                       fill_shift;
  mvd_pkg::history_t          hist_fill;
  mvd_pkg::history_t          hist_quiet;
  logic [mvd_pkg::SUM_W-1:0]  sum;
  logic [mvd_pkg::Z_W-1:0]    dev;
  logic                       quiet;
  logic [mvd_pkg::RUN_W-1:0]  high_inc;
  logic [mvd_pkg::RUN_W-1:0]  low_inc;

  assign z = {z_high_byte, z_low_byte[7:5]};

  assign warm_inc   = cur.warmup_count < mvd_pkg::WARMUP_CAP;
  assign warm_new   = warm_inc ? cur.warmup_count + 7'd1 : cur.warmup_count;
  assign fill_shift = warm_inc && (warm_new < cfg.fill_samples);

  // During the fill phase, advance the history by one, newest entry at the top.
  always_comb begin
    for (int i = 0; i < mvd_pkg::HISTORY_DEPTH - 1; i++) begin
      hist_fill[i] = fill_shift ? cur.z_history[i+1] : cur.z_history[i];
    end
    hist_fill[mvd_pkg::HISTORY_DEPTH-1] = fill_shift ? z
                                        : cur.z_history[mvd_pkg::HISTORY_DEPTH-1];
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < mvd_pkg::SUM_TAPS; i++) begin
      sum = sum + mvd_pkg::SUM_W'(hist_fill[i]);
    end
  end

  assign baseline = mvd_pkg::Z_W'(sum / mvd_pkg::SUM_W'(mvd_pkg::BASELINE_TAPS));
  assign dev      = (z < baseline) ? (baseline - z) : (z - baseline);
  assign quiet    = dev < cfg.quiet_threshold;

  always_comb begin
    for (int i = 0; i < mvd_pkg::HISTORY_DEPTH - 1; i++) begin
      hist_quiet[i] = quiet ? hist_fill[i+1] : hist_fill[i];
    end
    hist_quiet[mvd_pkg::HISTORY_DEPTH-1] = quiet ? z : hist_fill[mvd_pkg::HISTORY_DEPTH-1];
  end

  assign high_inc = cur.high_run + 5'd1;

  always_comb begin
    nxt              = cur;
    nxt.warmup_count = warm_new;
    nxt.z_history    = hist_quiet;
    low_inc          = '0;

    // Arrival: a run of large deviations once armed.
    if (warm_new > cfg.arm_samples) begin
      if (dev > cfg.detect_threshold) begin
        nxt.high_run = high_inc;
        if (high_inc > mvd_pkg::RUN_W'(cfg.enter_count)) begin
          nxt.high_run     = mvd_pkg::RUN_W'(cfg.enter_count) + mvd_pkg::ENTER_HOLD_OFFSET;
          nxt.present_flag = 1'b1;
          nxt.low_run      = '0;
          for (int i = 0; i < mvd_pkg::HISTORY_DEPTH; i++) begin
            if (i >= mvd_pkg::BASELINE_TAPS) begin
              nxt.z_history[i] = baseline;
            end
          end
        end
      end else begin
        nxt.high_run = '0;
      end
    end

    // Departure: a run of quiet samples while present.
    if (nxt.present_flag) begin
      if (quiet) begin
        low_inc     = nxt.low_run + 5'd1;
        nxt.low_run = low_inc;
        if (low_inc > mvd_pkg::RUN_W'(cfg.leave_count)) begin
          nxt.low_run       = mvd_pkg::RUN_W'(cfg.leave_count) + mvd_pkg::LEAVE_HOLD_OFFSET;
          nxt.present_flag  = 1'b0;
          nxt.vehicle_total = cur.vehicle_total + 32'd1;
          nxt.high_run      = '0;
        end
      end else begin
        nxt.low_run = '0;
      end
    end
  end

endmodule

/* rtl/core/magnetic_vehicle_detector_top.sv */
// Top level of the magnetic vehicle detector: handshakes, configuration and state registers.
//
// Takes one magnetometer Z sample per request and returns one result per sample: the
// running vehicle count, the presence flag and the baseline used for that sample. One
// sample is accepted every clock cycle while the output is not stalled; it is held in
// the input register and moves into the result register when that register is free or
// being emptied. The rate is set by the state loop: the 19-entry history shift, the
// eight-entry baseline sum and the run counters are all updated in the same cycle that
// moves a sample into the result register. Configuration writes are always ready and
// take effect on the next sample.
module magnetic_vehicle_detector_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_z_high_byte,
  input  logic [7:0]                    in_z_low_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mvd_pkg::TOTAL_W-1:0]   out_flow_count,
  output logic                          out_vehicle_present,
  output logic [mvd_pkg::Z_W-1:0]       out_baseline_level,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mvd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mvd_pkg::CFG_DATA_W-1:0] cfg_data
);

  mvd_pkg::cfg_t   cfg_r;
  mvd_pkg::state_t state_r;
  mvd_pkg::state_t state_nxt;

  logic                    in_valid_r;
  logic [7:0]              z_high_r;
  logic [7:0]              z_low_r;
  logic                    out_valid_r;
  logic [mvd_pkg::Z_W-1:0] baseline_nxt;
  logic                    advance;
  logic                    in_take;

  // Move the held sample on when the result register is free or being emptied.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quiet_threshold  <= mvd_pkg::QUIET_THRESHOLD_RST;
      cfg_r.detect_threshold <= mvd_pkg::DETECT_THRESHOLD_RST;
      cfg_r.enter_count      <= mvd_pkg::ENTER_COUNT_RST;
      cfg_r.leave_count      <= mvd_pkg::LEAVE_COUNT_RST;
      cfg_r.fill_samples     <= mvd_pkg::FILL_SAMPLES_RST;
      cfg_r.arm_samples      <= mvd_pkg::ARM_SAMPLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mvd_pkg::REG_QUIET_THRESHOLD:  cfg_r.quiet_threshold  <= cfg_data[mvd_pkg::Z_W-1:0];
        mvd_pkg::REG_DETECT_THRESHOLD: cfg_r.detect_threshold <= cfg_data[mvd_pkg::Z_W-1:0];
        mvd_pkg::REG_ENTER_COUNT:      cfg_r.enter_count  <= cfg_data[mvd_pkg::CNT_W-1:0];
        mvd_pkg::REG_LEAVE_COUNT:      cfg_r.leave_count  <= cfg_data[mvd_pkg::CNT_W-1:0];
        mvd_pkg::REG_FILL_SAMPLES:     cfg_r.fill_samples <= cfg_data[mvd_pkg::WARM_W-1:0];
        mvd_pkg::REG_ARM_SAMPLES:      cfg_r.arm_samples  <= cfg_data[mvd_pkg::WARM_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      z_high_r <= in_z_high_byte;
      z_low_r  <= in_z_low_byte;
    end
  end

  mvd_step u_step (
    .z_high_byte (z_high_r),
    .z_low_byte  (z_low_r),
    .cfg         (cfg_r),
    .cur         (state_r),
    .nxt         (state_nxt),
    .baseline    (baseline_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flow_count      <= state_nxt.vehicle_total;
      out_vehicle_present <= state_nxt.present_flag;
      out_baseline_level  <= baseline_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
